// ===== hw/rtl/qsl_pkg.sv =====
`timescale 1ns / 1ps
// qsl_pkg: shared types for the quicksort engine
// used by qsl_ctrl, qsl_dp and quicksort_lomuto_engine_top; no dependencies
package qsl_pkg;

  // one datapath operation per cycle, issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ_ISSUE,
    OP_READ_DONE,
    OP_READ_EMPTY,
    OP_SETUP,
    OP_CALL,
    OP_PIVOT,
    OP_SCAN_J,
    OP_SCAN_END,
    OP_CMP,
    OP_SW1,
    OP_SW2,
    OP_FIN1,
    OP_FIN2,
    OP_PART
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  // status from the datapath back to the controller
  typedef struct packed {
    logic out_full;   // result register holds a transfer not yet taken
    logic rd_avail;   // sorted data left to read
    logic count_ge2;  // at least two elements stored
    logic j_lt_hi;    // scan index below the pivot position
    logic cmp_le;     // element just read is <= pivot
    logic same_nj;    // swap slot equals scan index
    logic more;       // another range remains after this partition
  } dp_stat_t;

endpackage

// ===== hw/rtl/qsl_ram.sv =====
`timescale 1ns / 1ps
// qsl_ram: generic single-write, single-read ram with registered read
// no dependencies
module qsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/qsl_dp.sv =====
`timescale 1ns / 1ps
// qsl_dp: element store, index registers, range stack, counters and result register
// depends on qsl_pkg and qsl_ram
module qsl_dp #(
  parameter int MAX_ITEMS   = 1024,
  parameter int STACK_DEPTH = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  qsl_pkg::ctl_cmd_t  cmd,
  output qsl_pkg::dp_stat_t  stat,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [63:0]        m_tdata,
  output logic               m_tlast,
  output logic [1:0]         m_tuser
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = AW + 1;
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);
  localparam logic [SW-1:0] StackTop = SW'(STACK_DEPTH);

  logic [CW-1:0] count;
  logic [CW-1:0] rp;
  logic          sorted;
  logic          ovf;
  logic [31:0]   opcnt;
  logic [AW-1:0] lo, hi, j, nxt;
  logic [31:0]   pivot, va, vb;
  logic [SW-1:0] sp;
  logic [AW-1:0] stk_lo [STACK_DEPTH];
  logic [AW-1:0] stk_hi [STACK_DEPTH];

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data, rd_data;

  qsl_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [1:0] inc);
    logic [32:0] s;
    s = {1'b0, a} + {31'd0, inc};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // load slot: a new batch starts from zero
  logic [CW-1:0] eff_cnt;
  assign eff_cnt = sorted ? '0 : count;

  // store port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = nxt;
    wr_data = va;
    rd_en   = 1'b0;
    rd_addr = nxt;
    case (cmd.op)
      qsl_pkg::OP_LOAD: begin
        wr_en   = eff_cnt < MaxCount;
        wr_addr = eff_cnt[AW-1:0];
        wr_data = in_value;
      end
      qsl_pkg::OP_READ_ISSUE: begin
        rd_en   = 1'b1;
        rd_addr = rp[AW-1:0];
      end
      qsl_pkg::OP_CALL: begin
        rd_en   = 1'b1;
        rd_addr = hi;
      end
      qsl_pkg::OP_SCAN_J: begin
        rd_en   = 1'b1;
        rd_addr = j;
      end
      qsl_pkg::OP_SCAN_END, qsl_pkg::OP_CMP: begin
        rd_en   = 1'b1;
        rd_addr = nxt;
      end
      qsl_pkg::OP_SW1: begin
        wr_en   = 1'b1;
        wr_addr = nxt;
        wr_data = va;
      end
      qsl_pkg::OP_SW2: begin
        wr_en   = 1'b1;
        wr_addr = j;
        wr_data = vb;
      end
      qsl_pkg::OP_FIN1: begin
        wr_en   = 1'b1;
        wr_addr = nxt;
        wr_data = pivot;
      end
      qsl_pkg::OP_FIN2: begin
        wr_en   = 1'b1;
        wr_addr = hi;
        wr_data = vb;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // partition outcome: pick smaller side, push larger side
  logic [CW-1:0] lo1, hi1, p1, lhi, lsz, rlo, rsz;
  logic          lok, rok, small_ok, push;
  logic [CW-1:0] s_lo, s_hi, b_lo, b_hi;
  always_comb begin
    lo1 = {1'b0, lo};
    hi1 = {1'b0, hi};
    p1  = {1'b0, nxt};
    lok = p1 > lo1 + CW'(1);
    rok = p1 + CW'(1) < hi1;
    lhi = (p1 > lo1) ? p1 - CW'(1) : lo1;
    lsz = lhi - lo1;
    rlo = p1 + CW'(1);
    rsz = hi1 - rlo;
    if (!rok || lsz <= rsz) begin
      b_lo = rlo;
      b_hi = hi1;
      if (lok) begin
        s_lo = lo1; s_hi = lhi; small_ok = 1'b1; push = rok;
      end else begin
        s_lo = rlo; s_hi = hi1; small_ok = rok; push = 1'b0;
      end
    end else begin
      s_lo = rlo; s_hi = hi1; small_ok = 1'b1;
      b_lo = lo1; b_hi = lhi; push = lok;
    end
  end

  logic [SW-1:0] sp_dec;
  assign sp_dec = sp - SW'(1);

  assign stat.out_full  = m_tvalid && !m_tready;
  assign stat.rd_avail  = sorted && (rp < count);
  assign stat.count_ge2 = count >= CW'(2);
  assign stat.j_lt_hi   = j < hi;
  assign stat.cmp_le    = $signed(rd_data) <= $signed(pivot);
  assign stat.same_nj   = nxt == j;
  assign stat.more      = small_ok || (sp != '0);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rp       <= '0;
      sorted   <= 1'b0;
      ovf      <= 1'b0;
      opcnt    <= '0;
      sp       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (cmd.op)
        qsl_pkg::OP_LOAD: begin
          if (sorted) begin
            sorted <= 1'b0;
            rp     <= '0;
          end
          if (sorted || in_last) opcnt <= '0;
          if (eff_cnt < MaxCount) begin
            count <= eff_cnt + CW'(1);
            if (sorted) ovf <= 1'b0;
          end else begin
            count <= eff_cnt;
            ovf   <= 1'b1;
          end
        end
        qsl_pkg::OP_READ_DONE: begin
          rp <= rp + CW'(1);
        end
        qsl_pkg::OP_SETUP: begin
          sp     <= '0;
          sorted <= 1'b1;
          rp     <= '0;
        end
        qsl_pkg::OP_CALL: begin
          opcnt <= sat_add(opcnt, 2'd1);
        end
        qsl_pkg::OP_CMP: begin
          opcnt <= sat_add(opcnt, stat.cmp_le ? 2'd2 : 2'd1);
        end
        qsl_pkg::OP_PART: begin
          if (push && sp < StackTop) begin
            sp <= sp + SW'(1);
          end else if (!small_ok && sp != '0) begin
            sp <= sp_dec;
          end
        end
        default: begin
          sp <= sp;
        end
      endcase
      // result valid: set by a read, cleared by its transfer
      if (cmd.op == qsl_pkg::OP_READ_DONE || cmd.op == qsl_pkg::OP_READ_EMPTY) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      qsl_pkg::OP_READ_DONE: begin
        m_tdata <= {opcnt, rd_data};
        m_tlast <= (rp + CW'(1)) == count;
        m_tuser <= {ovf, 1'b0};
      end
      qsl_pkg::OP_READ_EMPTY: begin
        m_tdata <= {opcnt, 32'd0};
        m_tlast <= 1'b0;
        m_tuser <= {ovf, 1'b1};
      end
      qsl_pkg::OP_SETUP: begin
        lo <= '0;
        hi <= count[AW-1:0] - AW'(1);
      end
      qsl_pkg::OP_CALL: begin
        nxt <= lo;
        j   <= lo;
      end
      qsl_pkg::OP_PIVOT: begin
        pivot <= rd_data;
      end
      qsl_pkg::OP_CMP: begin
        va <= rd_data;
        if (!stat.cmp_le) begin
          j <= j + AW'(1);
        end else if (stat.same_nj) begin
          j   <= j + AW'(1);
          nxt <= nxt + AW'(1);
        end
      end
      qsl_pkg::OP_SW1, qsl_pkg::OP_FIN1: begin
        vb <= rd_data;
      end
      qsl_pkg::OP_SW2: begin
        j   <= j + AW'(1);
        nxt <= nxt + AW'(1);
      end
      qsl_pkg::OP_PART: begin
        if (push && sp < StackTop) begin
          stk_lo[sp[$clog2(STACK_DEPTH)-1:0]] <= b_lo[AW-1:0];
          stk_hi[sp[$clog2(STACK_DEPTH)-1:0]] <= b_hi[AW-1:0];
        end
        if (small_ok) begin
          lo <= s_lo[AW-1:0];
          hi <= s_hi[AW-1:0];
        end else if (sp != '0) begin
          lo <= stk_lo[sp_dec[$clog2(STACK_DEPTH)-1:0]];
          hi <= stk_hi[sp_dec[$clog2(STACK_DEPTH)-1:0]];
        end
      end
      default: begin
        pivot <= pivot;
      end
    endcase
  end

endmodule

// ===== hw/rtl/qsl_ctrl.sv =====
`timescale 1ns / 1ps
// qsl_ctrl: sequencer for loads, reads and the partition loop
// depends on qsl_pkg
module qsl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic              in_last,
  input  qsl_pkg::dp_stat_t stat,
  output qsl_pkg::ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SETUP, S_CALL, S_PIV, S_SCAN, S_CMP,
    S_SW1, S_SW2, S_FIN1, S_FIN2, S_PART
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !stat.out_full;

  // next state and operation
  always_comb begin
    state_next = state;
    cmd.op     = qsl_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (!in_mode) begin
            cmd.op = qsl_pkg::OP_LOAD;
            if (in_last) state_next = S_SETUP;
          end else if (stat.rd_avail) begin
            cmd.op     = qsl_pkg::OP_READ_ISSUE;
            state_next = S_RD;
          end else begin
            cmd.op = qsl_pkg::OP_READ_EMPTY;
          end
        end
      end
      S_RD: begin
        cmd.op     = qsl_pkg::OP_READ_DONE;
        state_next = S_IDLE;
      end
      S_SETUP: begin
        cmd.op     = qsl_pkg::OP_SETUP;
        state_next = stat.count_ge2 ? S_CALL : S_IDLE;
      end
      S_CALL: begin
        cmd.op     = qsl_pkg::OP_CALL;
        state_next = S_PIV;
      end
      S_PIV: begin
        cmd.op     = qsl_pkg::OP_PIVOT;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.j_lt_hi) begin
          cmd.op     = qsl_pkg::OP_SCAN_J;
          state_next = S_CMP;
        end else begin
          cmd.op     = qsl_pkg::OP_SCAN_END;
          state_next = S_FIN1;
        end
      end
      S_CMP: begin
        cmd.op     = qsl_pkg::OP_CMP;
        state_next = (stat.cmp_le && !stat.same_nj) ? S_SW1 : S_SCAN;
      end
      S_SW1: begin
        cmd.op     = qsl_pkg::OP_SW1;
        state_next = S_SW2;
      end
      S_SW2: begin
        cmd.op     = qsl_pkg::OP_SW2;
        state_next = S_SCAN;
      end
      S_FIN1: begin
        cmd.op     = qsl_pkg::OP_FIN1;
        state_next = S_FIN2;
      end
      S_FIN2: begin
        cmd.op     = qsl_pkg::OP_FIN2;
        state_next = S_PART;
      end
      S_PART: begin
        cmd.op     = qsl_pkg::OP_PART;
        state_next = stat.more ? S_CALL : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/quicksort_lomuto_engine_top.sv =====
`timescale 1ns / 1ps
// quicksort_lomuto_engine_top: batch quicksort engine, controller plus datapath
// depends on qsl_pkg, qsl_ctrl, qsl_dp, qsl_ram
//
// channel  dir  fields
// s_*      in   tdata: value[31:0]; tuser: mode; tlast: final_load
// m_*      out  tdata: sorted_value[31:0], op_count[63:32];
//               tuser: no_data[0], overflowed[1]; tlast: end_of_data
//
// a load is taken from idle; a read passes the store's registered read port
// the last load starts the sort: a range runs call, pivot, fin1, fin2, part;
// a comparison scan and cmp, a swap sw1 and sw2, all on one store port pair
// s_tready is low while sorting or reading, or while a result waits to be taken
// rst is synchronous; the store is not cleared and needs no clearing pass
module quicksort_lomuto_engine_top #(
  parameter int MAX_ITEMS   = 1024,
  parameter int STACK_DEPTH = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value
  input  logic        s_tuser,   // mode
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // sorted_value, op_count
  output logic [1:0]  m_tuser,   // no_data, overflowed
  output logic        m_tlast
);

  qsl_pkg::ctl_cmd_t cmd;
  qsl_pkg::dp_stat_t stat;

  qsl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_mode(s_tuser), .in_last(s_tlast), .stat(stat), .cmd(cmd)
  );

  qsl_dp #(.MAX_ITEMS(MAX_ITEMS), .STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_value(s_tdata), .in_last(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  // an empty read result carries zero data and no end mark
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0 && !m_tlast)
    else $error("empty read result with data");

  // no input transfer while a result is stalled
  a_nosteal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted over stalled result");

  // a read that finds data produces a non-empty result from the read-done step
  a_read: assert property (@(posedge clk) disable iff (rst)
    cmd.op == qsl_pkg::OP_READ_ISSUE |=> ##1 m_tvalid && !m_tuser[0])
    else $error("read issue without result");

endmodule

// ===== bench/quicksort_lomuto_engine_top_test.sv =====
`timescale 1ns / 1ps
// quicksort_lomuto_engine_top_test: self-checking bench for the quicksort engine
// depends on quicksort_lomuto_engine_top; predicts each batch sort and checks reads
module quicksort_lomuto_engine_top_test;

  localparam int MAX_ITEMS   = 1024;
  localparam int STACK_DEPTH = 11;
  localparam bit MODE_LOAD   = 1'b0;
  localparam bit MODE_READ   = 1'b1;

  typedef struct packed {
    logic [31:0] sorted_value;
    logic        end_of_data;
    logic        no_data;
    logic [31:0] op_count;
    logic        overflowed;
  } read_result_t;

  // scoreboard: mirrors the engine state and queues expected read results
  class sort_scoreboard;
    logic [31:0]  store [MAX_ITEMS];
    int unsigned  count, rd_ptr;
    logic [31:0]  ops;
    bit           ovf, sorted;
    read_result_t pending [$];
    int           errors, reads_checked, batches;

    function void bump();
      if (ops != 32'hFFFF_FFFF) ops++;
    endfunction

    function void swap_pair(int unsigned a, int unsigned b);
      logic [31:0] t;
      t = store[a]; store[a] = store[b]; store[b] = t;
    endfunction

    function int unsigned partition(int unsigned lo, int unsigned hi);
      logic [31:0] pv;
      int unsigned nx;
      pv = store[hi];
      nx = lo;
      for (int unsigned j = lo; j < hi; j++) begin
        bump();
        if ($signed(store[j]) <= $signed(pv)) begin
          bump();
          swap_pair(nx, j);
          nx++;
        end
      end
      swap_pair(nx, hi);
      return nx;
    endfunction

    function void sort_batch();
      int unsigned stk_lo [STACK_DEPTH];
      int unsigned stk_hi [STACK_DEPTH];
      int unsigned sp, lo, hi, p, lhi, slo, shi, blo, bhi;
      bit have, lok, rok, t;
      sp = 0; lo = 0;
      hi = (count > 0) ? count - 1 : 0;
      have = count >= 2;
      while (have) begin
        bump();
        p = partition(lo, hi);
        lhi = (p > lo) ? p - 1 : lo;
        lok = p > lo + 1;
        rok = p + 1 < hi;
        if ((lhi - lo) <= (hi - (p + 1)) || !rok) begin
          slo = lo; shi = lhi; blo = p + 1; bhi = hi;
          if (!lok) begin
            lok = rok; rok = 0; slo = p + 1; shi = hi;
          end
        end else begin
          slo = p + 1; shi = hi; blo = lo; bhi = lhi;
          t = lok; lok = rok; rok = t;
        end
        if (rok && sp < STACK_DEPTH) begin
          stk_lo[sp] = blo; stk_hi[sp] = bhi; sp++;
        end
        if (lok) begin
          lo = slo; hi = shi;
        end else if (sp > 0) begin
          sp--; lo = stk_lo[sp]; hi = stk_hi[sp];
        end else begin
          have = 0;
        end
      end
    endfunction

    function void note_input(bit mode, logic [31:0] value, bit final_load);
      read_result_t r;
      if (mode == MODE_LOAD) begin
        if (sorted) begin
          sorted = 0; count = 0; rd_ptr = 0; ops = 0; ovf = 0;
        end
        if (count < MAX_ITEMS) store[count++] = value;
        else ovf = 1;
        if (final_load) begin
          ops = 0; sort_batch(); rd_ptr = 0; sorted = 1; batches++;
        end
      end else begin
        if (sorted && rd_ptr < count) begin
          r.sorted_value = store[rd_ptr];
          r.end_of_data = (rd_ptr + 1 == count);
          r.no_data = 0;
          rd_ptr++;
        end else begin
          r.sorted_value = '0; r.end_of_data = 0; r.no_data = 1;
        end
        r.op_count = ops;
        r.overflowed = ovf;
        pending.push_back(r);
      end
    endfunction

    function void check_result(read_result_t got);
      read_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      reads_checked++;
      if (got.sorted_value !== e.sorted_value) begin
        $error("sorted_value expected %0d got %0d",
               $signed(e.sorted_value), $signed(got.sorted_value)); errors++;
      end
      if (got.end_of_data !== e.end_of_data) begin
        $error("end_of_data expected %0b got %0b", e.end_of_data, got.end_of_data);
        errors++;
      end
      if (got.no_data !== e.no_data) begin
        $error("no_data expected %0b got %0b", e.no_data, got.no_data); errors++;
      end
      if (got.op_count !== e.op_count) begin
        $error("op_count expected %0d got %0d", e.op_count, got.op_count); errors++;
      end
      if (got.overflowed !== e.overflowed) begin
        $error("overflowed expected %0b got %0b", e.overflowed, got.overflowed);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  sort_scoreboard sb;
  bit  hold_off = 0;
  bit  stim_done = 0;
  int  items_sent = 0;

  always #6 clk = ~clk;

  quicksort_lomuto_engine_top #(.MAX_ITEMS(MAX_ITEMS), .STACK_DEPTH(STACK_DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_value(bit narrow);
    int r;
    r = $urandom_range(0, 9);
    if (narrow) return 32'($signed($urandom_range(0, 15)) - 8);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  // one input transfer; a random gap, possibly none, before it unless back-to-back is asked for
  task automatic send_item(bit mode, logic [31:0] value, bit final_load, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= mode;
    s_tdata  <= value;
    s_tlast  <= final_load;
    do @(posedge clk); while (!s_tready);
    sb.note_input(mode, value, final_load);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drop_valid();
    s_tvalid <= 0;
    s_tlast  <= 0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // load a batch of n values and then read n + extra times
  task automatic run_batch(int n, int extra, bit narrow, bit no_gap);
    for (int i = 0; i < n; i++)
      send_item(MODE_LOAD, rand_value(narrow), i == n - 1, no_gap);
    for (int i = 0; i < n + extra; i++)
      send_item(MODE_READ, $urandom, $urandom_range(0, 1), no_gap);
  endtask

  // receiver: random ready, and a long hold-off on request
  initial begin
    int g;
    m_tready = 0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 0;
        repeat (60) @(negedge clk);
        hold_off = 0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          m_tready <= 0;
          repeat (g) @(negedge clk);
        end
        m_tready <= 1;
        @(negedge clk);
      end
    end
  end

  // result sampling
  always @(posedge clk) begin
    read_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.sorted_value = m_tdata[31:0];
      got.op_count     = m_tdata[63:32];
      got.no_data      = m_tuser[0];
      got.overflowed   = m_tuser[1];
      got.end_of_data  = m_tlast;
      sb.check_result(got);
    end
  end

  // stimulus
  initial begin
    int n;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: reads before any sort, single and tiny batches, extremes
    send_item(MODE_READ, 32'hFFFF_FFFF, 1, 0);
    send_item(MODE_READ, 32'h0, 0, 0);
    run_batch(1, 2, 0, 0);
    send_item(MODE_LOAD, 32'h8000_0000, 0, 0);
    send_item(MODE_LOAD, 32'h7FFF_FFFF, 0, 0);
    send_item(MODE_LOAD, 32'hFFFF_FFFF, 0, 0);
    send_item(MODE_LOAD, 32'h0000_0000, 0, 0);
    send_item(MODE_LOAD, 32'h8000_0000, 1, 0);
    for (int i = 0; i < 6; i++) send_item(MODE_READ, '0, 0, 0);
    run_batch(2, 0, 1, 0);
    // a partially read batch; the next load then starts a fresh batch
    run_batch(4, -2, 1, 0);
    wait_drained();

    // pressure: receiver holds off while sender keeps reading
    run_batch(6, 0, 0, 1);
    hold_off = 1;
    for (int i = 0; i < 6; i++) send_item(MODE_READ, '0, 0, 1);
    wait_drained();

    // overflow: a full store plus dropped loads, final mark on a dropped one
    for (int i = 0; i < MAX_ITEMS + 3; i++)
      send_item(MODE_LOAD, rand_value(i % 3 == 0), i == MAX_ITEMS + 2, 1);
    for (int i = 0; i < 20; i++) send_item(MODE_READ, '0, 0, 0);
    // a load after partial reads, then sort with many duplicates
    run_batch(40, 2, 1, 0);
    wait_drained();

    // random batches, mostly small
    while (items_sent < 1400) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      if ($urandom_range(0, 9) == 0) send_item(MODE_READ, $urandom, 0, 0);
      run_batch(n, $urandom_range(0, 9) == 0 ? 2 : 0, $urandom_range(0, 2) == 0, 0);
    end
    wait_drained();
    repeat (20) @(negedge clk);
    stim_done = 1;
  end

  // end of run
  initial begin
    wait (stim_done);
    $display("covered %0d transfers in %0d sorted batches, %0d reads checked",
             items_sent, sb.batches, sb.reads_checked);
    $display("including empty reads, overflow past %0d entries and output back-pressure",
             MAX_ITEMS);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
